// ===== hdl/source_token_scanner_macros.svh =====
// assertion macros shared by the scanner modules
// expects signals named clk and rst in the module that uses them
`ifndef SOURCE_TOKEN_SCANNER_MACROS_SVH
`define SOURCE_TOKEN_SCANNER_MACROS_SVH

// same-cycle implication, checked outside reset
`define STS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sts_pkg.sv =====
// shared types, constants and lookup functions of the source token scanner
// no dependencies
package sts_pkg;

  localparam int STS_WORD_BYTES   = 8;
  localparam int STS_LENGTH_LIMIT = 255;
  localparam int STS_LINE_BITS    = 16;
  localparam int STS_QUEUE_DEPTH  = 4;

  // token kinds
  localparam logic [4:0] KIND_IDENT  = 5'd0;
  localparam logic [4:0] KIND_LPAREN = 5'd1;
  localparam logic [4:0] KIND_RPAREN = 5'd2;
  localparam logic [4:0] KIND_LBRACE = 5'd3;
  localparam logic [4:0] KIND_RBRACE = 5'd4;
  localparam logic [4:0] KIND_COMMA  = 5'd5;
  localparam logic [4:0] KIND_DOT    = 5'd6;
  localparam logic [4:0] KIND_MINUS  = 5'd7;
  localparam logic [4:0] KIND_PLUS   = 5'd8;
  localparam logic [4:0] KIND_SEMI   = 5'd9;
  localparam logic [4:0] KIND_ASSIGN = 5'd10;
  localparam logic [4:0] KIND_STAR   = 5'd11;
  localparam logic [4:0] KIND_AMP    = 5'd12;
  localparam logic [4:0] KIND_QUOTE  = 5'd13;
  localparam logic [4:0] KIND_STRING = 5'd14;
  localparam logic [4:0] KIND_BOOL   = 5'd15;
  localparam logic [4:0] KIND_CHAR   = 5'd16;
  localparam logic [4:0] KIND_INT    = 5'd17;
  localparam logic [4:0] KIND_FLOAT  = 5'd18;
  localparam logic [4:0] KIND_ARRAY  = 5'd19;
  localparam logic [4:0] KIND_DOUBLE = 5'd20;
  localparam logic [4:0] KIND_CONST  = 5'd21;
  localparam logic [4:0] KIND_ELSE   = 5'd22;
  localparam logic [4:0] KIND_ELIF   = 5'd23;
  localparam logic [4:0] KIND_FUNC   = 5'd24;
  localparam logic [4:0] KIND_FOR    = 5'd25;
  localparam logic [4:0] KIND_IF     = 5'd26;
  localparam logic [4:0] KIND_OUT    = 5'd27;
  localparam logic [4:0] KIND_WHILE  = 5'd28;
  localparam logic [4:0] KIND_VOID   = 5'd29;

  // special bytes
  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_VTAB     = 8'h0B;
  localparam logic [7:0] CHAR_FORMFEED = 8'h0C;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_QUOTE    = 8'h22;
  localparam logic [7:0] CHAR_HASH     = 8'h23;

  // keyword table, first byte lowest, zero padded
  localparam int KW_COUNT = 17;
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h66,             // f
    48'h74756F,         // out
    48'h746E69,         // int
    48'h676E69727453,   // String
    48'h6C6F6F62,       // bool
    48'h7961727241,     // Array
    48'h74616F6C66,     // float
    48'h64696F76,       // void
    48'h656C62756F64,   // double
    48'h72616863,       // char
    48'h74736E6F63,     // const
    48'h6669,           // if
    48'h66696C65,       // elif
    48'h65736C65,       // else
    48'h656C696877,     // while
    48'h726F66,         // for
    48'h6E7275746572    // return
  };
  localparam logic [7:0] KW_LEN [KW_COUNT] = '{
    8'd1, 8'd3, 8'd3, 8'd6, 8'd4, 8'd5, 8'd5, 8'd4, 8'd6,
    8'd4, 8'd5, 8'd2, 8'd4, 8'd4, 8'd5, 8'd3, 8'd6
  };
  localparam logic [4:0] KW_KIND [KW_COUNT] = '{
    KIND_FUNC, KIND_OUT, KIND_INT, KIND_STRING, KIND_BOOL, KIND_ARRAY,
    KIND_FLOAT, KIND_VOID, KIND_DOUBLE, KIND_CHAR, KIND_CONST, KIND_IF,
    KIND_ELIF, KIND_ELSE, KIND_WHILE, KIND_FOR, KIND_OUT
  };

  // one queue entry: what a single byte asks the output side to send
  typedef struct packed {
    logic        word_valid;
    logic [4:0]  word_kind;
    logic [63:0] word_text;
    logic [7:0]  word_length;
    logic [15:0] line_number;
    logic        punct_valid;
    logic [4:0]  punct_kind;
  } sts_cmd_t;

  // single-character punctuators, identifier kind when none
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h2C:   k = KIND_COMMA;
      8'h2E:   k = KIND_DOT;
      8'h2D:   k = KIND_MINUS;
      8'h2B:   k = KIND_PLUS;
      8'h3B:   k = KIND_SEMI;
      8'h3D:   k = KIND_ASSIGN;
      8'h2A:   k = KIND_STAR;
      8'h26:   k = KIND_AMP;
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

  // parallel keyword match; bytes past the length are zero, first entry wins
  function automatic logic [4:0] classify(input logic [63:0] text,
                                          input logic [7:0] len);
    logic [4:0] k;
    k = KIND_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (len == KW_LEN[i] && text == {16'h0, KW_TEXT[i]}) begin
        k = KW_KIND[i];
      end
    end
    return k;
  endfunction

endpackage

// ===== hdl/sts_front.sv =====
// front end: accepts bytes, keeps the pending word and modes, classifies words
// depends on sts_pkg
module sts_front import sts_pkg::*; #(
  parameter int WORD_BYTES   = STS_WORD_BYTES,
  parameter int LENGTH_LIMIT = STS_LENGTH_LIMIT,
  parameter int LINE_BITS    = STS_LINE_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       q_full,
  output logic       push,
  output sts_cmd_t   cmd
);

  localparam int TextBits = 8 * WORD_BYTES;
  localparam int LenBits  = $clog2(LENGTH_LIMIT + 1);

  logic [TextBits-1:0]  pending_text, pending_text_next, text_app;
  logic [LenBits-1:0]   pending_length, pending_length_next, len_app;
  logic                 string_mode, string_mode_next;
  logic                 comment_mode, comment_mode_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;

  logic        fire;
  logic [31:0] len_wide, line_wide;
  logic [7:0]  len_out;
  logic [15:0] line_out;
  logic        is_space;
  logic [4:0]  pk;
  logic        has_word;

  assign s_tready = !q_full;
  assign fire     = s_tvalid && s_tready;

  always_comb begin
    len_wide  = 32'(pending_length);
    line_wide = 32'(line_count);
    len_out   = (len_wide > 32'd255) ? 8'hFF : len_wide[7:0];
    line_out  = (line_wide > 32'd65535) ? 16'hFFFF : line_wide[15:0];
    has_word  = (pending_length != '0);
    is_space  = (s_tdata == CHAR_SPACE) || (s_tdata == CHAR_TAB) ||
                (s_tdata == CHAR_VTAB) || (s_tdata == CHAR_FORMFEED) ||
                (s_tdata == CHAR_CR);
    pk        = punct_kind(s_tdata);

    // word with this byte appended
    text_app = pending_text;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (len_wide == 32'(i)) begin
        text_app[i*8 +: 8] = s_tdata;
      end
    end
    len_app = (len_wide < 32'(LENGTH_LIMIT)) ? pending_length + LenBits'(1) : pending_length;

    pending_text_next   = pending_text;
    pending_length_next = pending_length;
    string_mode_next    = string_mode;
    comment_mode_next   = comment_mode;
    line_count_next     = line_count;

    cmd.word_valid  = 1'b0;
    cmd.word_kind   = classify(64'(pending_text), len_out);
    cmd.word_text   = 64'(pending_text);
    cmd.word_length = len_out;
    cmd.line_number = line_out;
    cmd.punct_valid = 1'b0;
    cmd.punct_kind  = pk;

    priority if (s_tdata == CHAR_NEWLINE) begin
      if (line_count != '1) line_count_next = line_count + LINE_BITS'(1);
      comment_mode_next = 1'b0;
    end else if (comment_mode) begin
      // skipped up to the newline
    end else if (s_tdata == CHAR_QUOTE) begin
      string_mode_next    = !string_mode;
      cmd.word_valid      = string_mode && has_word;
      cmd.punct_valid     = 1'b1;
      cmd.punct_kind      = KIND_QUOTE;
      pending_text_next   = '0;
      pending_length_next = '0;
    end else if (string_mode) begin
      pending_text_next   = text_app;
      pending_length_next = len_app;
    end else if (s_tdata == CHAR_HASH) begin
      pending_text_next   = '0;
      pending_length_next = '0;
      comment_mode_next   = 1'b1;
    end else if (is_space) begin
      cmd.word_valid      = has_word;
      pending_text_next   = '0;
      pending_length_next = '0;
    end else if (pk != KIND_IDENT) begin
      cmd.word_valid      = has_word;
      cmd.punct_valid     = 1'b1;
      pending_text_next   = '0;
      pending_length_next = '0;
    end else begin
      pending_text_next   = text_app;
      pending_length_next = len_app;
    end

    push = fire && (cmd.word_valid || cmd.punct_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_text   <= '0;
      pending_length <= '0;
      string_mode    <= 1'b0;
      comment_mode   <= 1'b0;
      line_count     <= LINE_BITS'(1);
    end else if (fire) begin
      pending_text   <= pending_text_next;
      pending_length <= pending_length_next;
      string_mode    <= string_mode_next;
      comment_mode   <= comment_mode_next;
      line_count     <= line_count_next;
    end
  end

endmodule

// ===== hdl/sts_queue.sv =====
// short command queue between the front end and the token output side
// depends on sts_pkg and source_token_scanner_macros.svh
`include "source_token_scanner_macros.svh"
module sts_queue import sts_pkg::*; #(
  parameter int DEPTH = STS_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  sts_cmd_t push_cmd,
  output logic     full,
  output logic     valid,
  output sts_cmd_t head,
  input  logic     pop
);

  localparam int PtrBits   = $clog2(DEPTH);
  localparam int CountBits = $clog2(DEPTH + 1);

  sts_cmd_t             entries [DEPTH];
  logic [PtrBits-1:0]   wr_ptr, rd_ptr;
  logic [CountBits-1:0] count;

  assign full  = (count == CountBits'(DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr + PtrBits'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr + PtrBits'(1);
      end
      if (push && !pop) count <= count + CountBits'(1);
      else if (pop && !push) count <= count - CountBits'(1);
    end
  end

  `STS_ASSERT_NOW(a_pop_nonempty, pop, valid, "queue popped while empty")
  `STS_ASSERT_NOW(a_push_room, push, !full || pop, "queue pushed while full")
  `STS_ASSERT_NEXT(a_count_grow, push && !pop, count == $past(count) + CountBits'(1), "queue count did not grow")

endmodule

// ===== hdl/sts_back.sv =====
// output side: unpacks queue commands into one or two tokens, registered output
// depends on sts_pkg and source_token_scanner_macros.svh
`include "source_token_scanner_macros.svh"
module sts_back import sts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  sts_cmd_t    q_head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,
  output logic        m_tlast
);

  logic load;
  logic send_word;
  logic phase;  // word token of the head entry already sent

  assign load      = q_valid && (!m_tvalid || m_tready);
  assign send_word = q_head.word_valid && !phase;
  assign pop       = load && (!send_word || !q_head.punct_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      phase    <= send_word && q_head.punct_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_word) begin
        m_tdata <= {3'b000, q_head.word_length, q_head.word_text,
                    q_head.line_number, q_head.word_kind};
        m_tlast <= !q_head.punct_valid;
      end else begin
        m_tdata <= {3'b000, 8'h00, 64'h0, q_head.line_number, q_head.punct_kind};
        m_tlast <= 1'b1;
      end
    end
  end

  `STS_ASSERT_NOW(a_split_pending, m_tvalid && !m_tlast, phase, "word token shown without its follower pending")
  `STS_ASSERT_NOW(a_split_head, phase, q_valid, "follower token lost from queue head")

endmodule

// ===== hdl/source_token_scanner.sv =====
// top level of the source token scanner: front end, command queue, output side
// depends on sts_pkg, sts_front, sts_queue and sts_back
//
// The scanner takes source text one byte per item on the s_ stream and sends
// tokens on the m_ stream. It accepts a byte every clock cycle as long as the
// command queue has room. Most bytes give no token or one; a punctuator or
// closing quote that ends a non-empty word gives two (the word, then the
// punctuator or quotation), and the output register sends them in that order.
// Such a byte always follows a word byte that gives no token, so with m_tready
// held high the output keeps up and the sustained rate is one byte per cycle;
// a stalled output fills the queue and drops s_tready until a queue entry is
// released. From byte accept to token valid a command passes the queue entry,
// written at the accept edge, and then the output register; the second token
// of a byte enters the output register once the first is taken.
// Words are held as their first WORD_BYTES bytes plus a length saturating at
// LENGTH_LIMIT; keywords are matched in parallel against the pending word as
// the terminator arrives. Lines are counted in LINE_BITS bits, saturating.
// m_tlast marks the last token caused by one byte.
module source_token_scanner import sts_pkg::*; #(
  parameter int WORD_BYTES   = STS_WORD_BYTES,   // 6 to 8
  parameter int LENGTH_LIMIT = STS_LENGTH_LIMIT, // 8 to 65535
  parameter int LINE_BITS    = STS_LINE_BITS,    // 8 to 32
  parameter int QUEUE_DEPTH  = STS_QUEUE_DEPTH   // 2 or more
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // token_kind[4:0], line_number[20:5],
                                 // word_text[84:21], word_length[92:85], zero
  output logic        m_tlast    // last_of_run
);

  // front to queue
  logic     push;
  sts_cmd_t push_cmd;
  logic     q_full;

  // queue to output side
  logic     q_valid;
  sts_cmd_t q_head;
  logic     pop;

  // byte intake and word classification
  sts_front #(
    .WORD_BYTES   (WORD_BYTES),
    .LENGTH_LIMIT (LENGTH_LIMIT),
    .LINE_BITS    (LINE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // decouples intake from a stalled output
  sts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (pop)
  );

  // token sequencing and output register
  sts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/sv/source_token_scanner_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for source_token_scanner: streams source bytes in,
// predicts the token stream and checks every token field
// depends on sts_pkg and the source_token_scanner rtl

module source_token_scanner_test;
  import sts_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 730;

  typedef struct {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [63:0] text;
    logic [7:0]  len;
    logic        last;
  } token_t;

  // token predictor plus the queue of tokens still owed by the scanner
  class token_scoreboard;
    logic [63:0] word_text;
    int unsigned word_len;
    bit          in_string;
    bit          in_comment;
    logic [15:0] line_count;
    string       kw_names[17];
    logic [4:0]  kw_kinds[17];
    token_t      owed[$];
    token_t      fresh[$];
    int unsigned errors;
    int unsigned tokens_checked;
    int unsigned longest_word;
    bit [31:0]   kinds_seen;

    function new();
      kw_names = '{"f", "out", "int", "String", "bool", "Array", "float", "void",
                   "double", "char", "const", "if", "elif", "else", "while", "for",
                   "return"};
      kw_kinds = '{KIND_FUNC, KIND_OUT, KIND_INT, KIND_STRING, KIND_BOOL, KIND_ARRAY,
                   KIND_FLOAT, KIND_VOID, KIND_DOUBLE, KIND_CHAR, KIND_CONST, KIND_IF,
                   KIND_ELIF, KIND_ELSE, KIND_WHILE, KIND_FOR, KIND_OUT};
      word_text  = '0;
      word_len   = 0;
      in_string  = 0;
      in_comment = 0;
      line_count = 16'd1;
      errors = 0;
      tokens_checked = 0;
      longest_word = 0;
      kinds_seen = '0;
    endfunction

    function logic [4:0] word_kind();
      logic [63:0] kw_text;
      for (int k = 0; k < 17; k++) begin
        if (kw_names[k].len() == word_len) begin
          kw_text = '0;
          for (int i = 0; i < kw_names[k].len(); i++) kw_text[8*i +: 8] = kw_names[k][i];
          if (kw_text == word_text) return kw_kinds[k];
        end
      end
      return KIND_IDENT;
    endfunction

    function void add_token(logic [4:0] kind, bit with_word);
      token_t t;
      t.kind = kind;
      t.line = line_count;
      t.text = with_word ? word_text : 64'd0;
      t.len  = with_word ? 8'(word_len) : 8'd0;
      t.last = 1'b0;
      fresh.push_back(t);
    endfunction

    // pending word goes out only when it holds something
    function void flush_word();
      if (word_len != 0) add_token(word_kind(), 1'b1);
    endfunction

    function void clear_word();
      word_text = '0;
      word_len  = 0;
    endfunction

    function void add_byte(logic [7:0] c);
      if (word_len < STS_WORD_BYTES) word_text[8*word_len +: 8] = c;
      if (word_len < STS_LENGTH_LIMIT) word_len++;
      if (word_len > longest_word) longest_word = word_len;
    endfunction

    function logic [4:0] punct_of(logic [7:0] c);
      case (c)
        "(":     return KIND_LPAREN;
        ")":     return KIND_RPAREN;
        "{":     return KIND_LBRACE;
        "}":     return KIND_RBRACE;
        ",":     return KIND_COMMA;
        ".":     return KIND_DOT;
        "-":     return KIND_MINUS;
        "+":     return KIND_PLUS;
        ";":     return KIND_SEMI;
        "=":     return KIND_ASSIGN;
        "*":     return KIND_STAR;
        "&":     return KIND_AMP;
        default: return KIND_IDENT;
      endcase
    endfunction

    // accepted byte: update the scanner state, queue the tokens it causes;
    // returns 0 for a byte swallowed by a comment
    function bit note_byte(logic [7:0] c);
      fresh.delete();
      if (c == CHAR_NEWLINE) begin
        if (line_count != 16'hFFFF) line_count++;
        in_comment = 0;
        return 1;
      end
      if (in_comment) return 0;
      if (c == CHAR_QUOTE) begin
        in_string = !in_string;
        // opening quote drops the pending word, closing quote classifies it
        if (!in_string) flush_word();
        add_token(KIND_QUOTE, 1'b0);
        clear_word();
      end else if (in_string) begin
        add_byte(c);
      end else if (c == CHAR_HASH) begin
        clear_word();
        in_comment = 1;
      end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VTAB ||
                   c == CHAR_FORMFEED || c == CHAR_CR) begin
        flush_word();
        clear_word();
      end else if (punct_of(c) != KIND_IDENT) begin
        flush_word();
        add_token(punct_of(c), 1'b0);
        clear_word();
      end else begin
        add_byte(c);
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) owed.push_back(fresh[i]);
      return 1;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected token, expected none, actual kind %0d text %0h",
                 $time, got.kind, got.text);
        return;
      end
      want = owed.pop_front();
      tokens_checked++;
      kinds_seen[got.kind] = 1'b1;
      compare_field("token_kind", want.kind, got.kind);
      compare_field("line_number", want.line, got.line);
      compare_field("word_text", want.text, got.text);
      compare_field("word_length", want.len, got.len);
      compare_field("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;   // token_kind[4:0], line_number[20:5], word_text[84:21],
                          // word_length[92:85], zero
  logic        m_tlast;   // last_of_run

  token_scoreboard sb = new();

  bit          send_gaps  = 0;   // sender idles in bursts when set
  bit          sink_stall = 0;   // receiver stalls in bursts when set
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int unsigned bytes_sent = 0;

  source_token_scanner DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (sink_stall && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // token monitor
  always @(posedge clk) begin
    token_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tdata[4:0];
      got.line = m_tdata[20:5];
      got.text = m_tdata[84:21];
      got.len  = m_tdata[92:85];
      got.last = m_tlast;
      sb.check_token(got);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: watchdog expired with %0d tokens owed", $time, sb.owed.size());
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] c);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    void'(sb.note_byte(c));
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // hold the sender until every owed token has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.owed.size() != 0);
  endtask

  function automatic logic [7:0] pick_terminator();
    string puncts;
    puncts = "(){},.-+;=*&";
    case ($urandom_range(0, 9))
      0, 1, 2: return CHAR_SPACE;
      3: begin
        case ($urandom_range(0, 3))
          0:       return CHAR_TAB;
          1:       return CHAR_VTAB;
          2:       return CHAR_FORMFEED;
          default: return CHAR_CR;
        endcase
      end
      4, 5, 6: return puncts[$urandom_range(0, 11)];
      7:       return CHAR_QUOTE;
      8:       return CHAR_HASH;
      default: return CHAR_NEWLINE;
    endcase
  endfunction

  function automatic string random_ident(input int n);
    string letters;
    string s;
    letters = "abcdefghilnorstuvwxyzASC0123456789_";
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(letters[$urandom_range(0, letters.len()-1)])};
    return s;
  endfunction

  // one well-formed fragment with random content, or a burst of noise
  task automatic random_fragment();
    string w;
    int    pick;
    int    n;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      w = sb.kw_names[$urandom_range(0, 16)];
      // near misses: one byte changed or one byte added
      if ($urandom_range(0, 4) == 0) w[$urandom_range(0, w.len()-1)] = "e";
      else if ($urandom_range(0, 6) == 0) w = {w, random_ident(1)};
      send_text(w);
      send_byte(pick_terminator());
    end else if (pick < 55) begin
      send_text(random_ident($urandom_range(1, 10)));
      send_byte(pick_terminator());
    end else if (pick < 67) begin
      send_byte(CHAR_QUOTE);
      if ($urandom_range(0, 2) == 0) begin
        send_text(sb.kw_names[$urandom_range(0, 16)]);
      end else begin
        n = $urandom_range(0, 10);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255)); while (c == CHAR_QUOTE);
          send_byte(c);
        end
      end
      send_byte(CHAR_QUOTE);
    end else if (pick < 74) begin
      send_byte(CHAR_HASH);
      n = $urandom_range(0, 6);
      repeat (n) begin
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_NEWLINE);
        send_byte(c);
      end
      send_byte(CHAR_NEWLINE);
    end else if (pick < 79) begin
      send_byte(CHAR_NEWLINE);
    end else if (pick < 93) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end else begin
      // long words: past the stored bytes, now and then past the length limit
      if ($urandom_range(0, 3) == 0) n = $urandom_range(250, 300);
      else n = $urandom_range(9, 20);
      send_text(random_ident(n));
      send_byte(pick_terminator());
    end
  endtask

  initial begin
    bit drained_mid;
    drained_mid = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every punctuator, return vs out, the whitespace bytes,
    // dropped words, strings, newline inside a word, extreme byte values
    send_text("f(){},.-+;=*&return out");
    send_byte(CHAR_TAB);
    send_text("int");
    send_byte(CHAR_VTAB);
    send_byte(CHAR_FORMFEED);
    send_text("x");
    send_byte(CHAR_CR);
    send_text("ab#c(");
    send_byte(CHAR_NEWLINE);
    send_text("zz\"int\"\"\"el");
    send_byte(CHAR_NEWLINE);
    send_text("if ");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("\"a#(");
    send_byte(CHAR_NEWLINE);
    send_text("b\"abcdefghi;");
    wait_drained();

    // random fragments, gaps and stalls switched on and off in stretches
    while (bytes_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) send_gaps  = !send_gaps;
      if ($urandom_range(0, 7) == 0) sink_stall = !sink_stall;
      if (!drained_mid && bytes_sent > RANDOM_ITEMS / 2) begin
        wait_drained();
        drained_mid = 1;
      end
      random_fragment();
    end

    // last part, no idling: leave any string or comment, then a few
    // tokens back to back
    send_gaps  = 0;
    sink_stall = 0;
    if (sb.in_string) send_byte(CHAR_QUOTE);
    send_byte(CHAR_NEWLINE);
    send_text("while(x);");
    send_byte(CHAR_NEWLINE);
    send_text("\"elif\" ");

    wait_drained();
    repeat (10) @(posedge clk);

    $display("run covered %0d bytes and %0d tokens, %0d of 30 token kinds seen",
             bytes_sent, sb.tokens_checked, $countones(sb.kinds_seen));
    $display("longest word %0d bytes, final line count %0d", sb.longest_word,
             sb.line_count);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sts_pkg.sv
hdl/sts_front.sv
hdl/sts_queue.sv
hdl/sts_back.sv
hdl/source_token_scanner.sv
tb/sv/source_token_scanner_test.sv
